// File: design/bqf_pkg.sv
// Shared types and constants of the biquad filter: coefficient set and register indexes.
package bqf_pkg;

    localparam int COEFF_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEFF_W-1:0] B0_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_GAIN_0 = 3'd0,
        CFG_FF_GAIN_1 = 3'd1,
        CFG_FF_GAIN_2 = 3'd2,
        CFG_FB_GAIN_1 = 3'd3,
        CFG_FB_GAIN_2 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEFF_W-1:0] b0;
        logic signed [COEFF_W-1:0] b1;
        logic signed [COEFF_W-1:0] b2;
        logic signed [COEFF_W-1:0] a1;
        logic signed [COEFF_W-1:0] a2;
    } t_coeffs;

endpackage

// File: design/biquad_iir_filter.sv
// Top level of the direct form I biquad filter with its handshake stages.
//
// Usage: samples arrive on the input channel (i_in_valid, o_in_stall,
// i_sample_in, i_restart) and filtered samples leave on the output channel
// (o_out_valid, i_out_stall, o_sample_out). A transfer happens at a rising
// edge where valid is high and stall is low. Each input transfer yields
// exactly one output transfer, in order.
// A sample taken in is held in the input register, passes through the
// multiply, add, round and saturate logic and is shown in the result
// register once it advances. The filter takes one sample per cycle while
// the receiver does not stall; this is possible because the feedback from
// the last output into the next sum is closed through the result register.
// When the receiver stalls, the result register holds its sample and the
// input register can still take one more sample; only when both are full is
// o_in_stall raised. Setting i_restart with a sample clears the filter
// history before that sample is processed. Coefficients are written through
// i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only while
// the filter is idle; the block does not enforce it. Indexes beyond the last
// register are ignored. Reset is synchronous and active low: it empties both
// stages, clears the history and loads coefficients for a unity pass-through.
module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample_in,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_sample_out,
    input  logic                            i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bqf_pkg::COEFF_W-1:0]     i_cfg_data
);

    bqf_pkg::t_coeffs coeffs;

    logic                           r_in_valid, n_in_valid;
    logic                           r_out_valid, n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_restart;
    logic                           in_accept;
    logic                           advance;

    // The held sample moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample  <= i_sample_in;
            r_restart <= i_restart;
        end
    end

    bqf_coeff_regs u_coeff_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coeffs    (coeffs)
    );

    bqf_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_sample  (r_sample),
        .i_restart (r_restart),
        .i_coeffs  (coeffs),
        .o_sample  (o_sample_out)
    );

    assign o_out_valid = r_out_valid;

endmodule

// File: design/bqf_coeff_regs.sv
// Coefficient register bank of the biquad filter, written through the configuration port.
module bqf_coeff_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bqf_pkg::COEFF_W-1:0]     i_cfg_data,
    output bqf_pkg::t_coeffs                o_coeffs
);

    bqf_pkg::t_coeffs r_coeffs;
    bqf_pkg::t_coeffs n_coeffs;

    always_comb begin
        n_coeffs = r_coeffs;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bqf_pkg::CFG_FF_GAIN_0: n_coeffs.b0 = i_cfg_data;
                bqf_pkg::CFG_FF_GAIN_1: n_coeffs.b1 = i_cfg_data;
                bqf_pkg::CFG_FF_GAIN_2: n_coeffs.b2 = i_cfg_data;
                bqf_pkg::CFG_FB_GAIN_1: n_coeffs.a1 = i_cfg_data;
                bqf_pkg::CFG_FB_GAIN_2: n_coeffs.a2 = i_cfg_data;
                default:                n_coeffs = r_coeffs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs.b0 <= bqf_pkg::B0_RESET;
            r_coeffs.b1 <= '0;
            r_coeffs.b2 <= '0;
            r_coeffs.a1 <= '0;
            r_coeffs.a2 <= '0;
        end else begin
            r_coeffs <= n_coeffs;
        end
    end

    assign o_coeffs = r_coeffs;

endmodule

// File: design/bqf_datapath.sv
// Biquad arithmetic: history registers, five products, rounding, saturation and the result.
module bqf_datapath #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_restart,
    input  bqf_pkg::t_coeffs               i_coeffs,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int FB     = COEFF_FRAC_BITS;
    localparam int PROD_W = SW + bqf_pkg::COEFF_W;
    // Five products need three guard bits; the rounding constant may need more.
    localparam int ACC_A  = PROD_W + 3;
    localparam int ACC_W  = (ACC_A > FB + 1) ? ACC_A : FB + 2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    logic signed [SW-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [SW-1:0] h_x1, h_x2, h_y1, h_y2;

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_shifted;
    logic [ACC_W-SW:0]        acc_upper;
    logic                     in_range;
    logic signed [SW-1:0]     n_y;

    // A restart clears the history seen by this sample.
    assign h_x1 = i_restart ? '0 : r_x1;
    assign h_x2 = i_restart ? '0 : r_x2;
    assign h_y1 = i_restart ? '0 : r_y1;
    assign h_y2 = i_restart ? '0 : r_y2;

    assign p_b0 = i_coeffs.b0 * i_sample;
    assign p_b1 = i_coeffs.b1 * h_x1;
    assign p_b2 = i_coeffs.b2 * h_x2;
    assign p_a1 = i_coeffs.a1 * h_y1;
    assign p_a2 = i_coeffs.a2 * h_y2;

    assign acc_sum = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
                   - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;

    // Arithmetic shift gives the floor of the division.
    assign acc_shifted = acc_sum >>> FB;

    // In range when every bit from the sample sign upwards agrees.
    assign acc_upper = acc_shifted[ACC_W-1:SW-1];
    assign in_range  = (&acc_upper) || !(|acc_upper);

    always_comb begin
        if (in_range) begin
            n_y = acc_shifted[SW-1:0];
        end else begin
            n_y = {acc_shifted[ACC_W-1], {(SW-1){~acc_shifted[ACC_W-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_step) begin
            r_x2 <= h_x1;
            r_x1 <= i_sample;
            r_y2 <= h_y1;
            r_y1 <= n_y;
        end
    end

    // The latest output history is the result register.
    assign o_sample = r_y1;

endmodule

// File: design/bqf_checker.sv
// Port-level checks of the biquad filter and the bind that attaches them.
module bqf_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0]  o_sample_out
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_sample_out))
        else $error("output sample changed while stalled");

    // Input stalls only when both stages are full and the receiver stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

    // A sample taken in is expected as a valid result once it has passed both stages.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##2 o_out_valid)
        else $error("no result two cycles after an input transfer");

endmodule

bind biquad_iir_filter bqf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqf_checker (.*);
